// ===== sv/servo_command_string_parser_defines.svh =====
// ----------------------------------------------------------------------------
// Servo command string parser: assertion macros
// Shared property forms for the checker of the parser.
// ----------------------------------------------------------------------------
`ifndef SERVO_COMMAND_STRING_PARSER_DEFINES_SVH
`define SERVO_COMMAND_STRING_PARSER_DEFINES_SVH

// same-cycle implication, held off while in reset
`define SCSP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("scsp: property failed");

// next-cycle implication, held off while in reset
`define SCSP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("scsp: property failed");

`endif

// ===== sv/scsp_pkg.sv =====
// ----------------------------------------------------------------------------
// scsp_pkg
// Types and constants shared by the servo command string parser modules.
// ----------------------------------------------------------------------------
package scsp_pkg;

  localparam int SERVO_COUNT = 8;
  localparam int BIAS_IW     = (SERVO_COUNT > 1) ? $clog2(SERVO_COUNT) : 1;

  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_P     = 8'h50;
  localparam logic [7:0] CH_T     = 8'h54;
  localparam logic [7:0] CH_S     = 8'h53;
  localparam logic [7:0] CH_D     = 8'h44;
  localparam logic [7:0] CH_C     = 8'h43;
  localparam logic [7:0] CH_K     = 8'h4B;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_NUL   = 8'h00;

  localparam logic signed [31:0] S5_MAX  = 32'sd2000;
  localparam logic signed [31:0] S5_MIN  = 32'sd1200;
  localparam logic signed [31:0] S3_MAX  = 32'sd1700;
  localparam logic signed [31:0] S12_MAX = 32'sd2100;
  localparam logic signed [31:0] S12_MIN = 32'sd900;

  localparam logic signed [10:0] BIAS_MIN = -11'sd100;
  localparam logic signed [10:0] BIAS_MAX = 11'sd100;

  typedef enum logic [1:0] {
    KIND_MOVE = 2'd0,
    KIND_BIAS = 2'd1,
    KIND_STOP = 2'd2
  } kind_t;

  typedef struct packed {
    logic               valid;
    kind_t              kind;
    logic [15:0]        servo;
    logic [15:0]        duration;
    logic signed [7:0]  offset;
  } res_t;

  typedef struct packed {
    logic               en;
    logic [BIAS_IW-1:0] idx;
    logic signed [7:0]  value;
  } bias_wr_t;

endpackage

// ===== sv/scsp_bias_table.sv =====
// ----------------------------------------------------------------------------
// scsp_bias_table
// Per-servo signed bias entries; reads beyond the table return zero.
// ----------------------------------------------------------------------------
module scsp_bias_table (
  input  logic                     clk,
  input  logic                     rst_n,
  input  scsp_pkg::bias_wr_t       wr,
  input  logic [15:0]              rd_servo,
  output logic signed [7:0]        rd_bias
);

  logic signed [7:0] bias_r [scsp_pkg::SERVO_COUNT];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < scsp_pkg::SERVO_COUNT; k++) bias_r[k] <= 8'sd0;
    end else if (wr.en) begin
      bias_r[wr.idx] <= wr.value;
    end
  end

  always_comb begin
    if (rd_servo < 16'(scsp_pkg::SERVO_COUNT)) begin
      rd_bias = bias_r[rd_servo[scsp_pkg::BIAS_IW-1:0]];
    end else begin
      rd_bias = 8'sd0;
    end
  end

endmodule

// ===== sv/scsp_pulse_shape.sv =====
// ----------------------------------------------------------------------------
// scsp_pulse_shape
// Clamp the pulse by servo index, add the bias and saturate to 0..65535.
// ----------------------------------------------------------------------------
module scsp_pulse_shape (
  input  logic signed [31:0] pulse_acc,
  input  logic [15:0]        servo,
  input  logic signed [7:0]  bias,
  output logic [15:0]        pulse
);

  logic signed [31:0] clamped;
  logic signed [32:0] biased;

  always_comb begin
    clamped = pulse_acc;
    if (servo == 16'd5) begin
      if (clamped > scsp_pkg::S5_MAX) clamped = scsp_pkg::S5_MAX;
      if (clamped < scsp_pkg::S5_MIN) clamped = scsp_pkg::S5_MIN;
    end
    if (servo == 16'd3) begin
      if (clamped > scsp_pkg::S3_MAX) clamped = scsp_pkg::S3_MAX;
    end
    if (servo == 16'd1 || servo == 16'd2) begin
      if (clamped > scsp_pkg::S12_MAX) clamped = scsp_pkg::S12_MAX;
      if (clamped < scsp_pkg::S12_MIN) clamped = scsp_pkg::S12_MIN;
    end
    biased = {clamped[31], clamped} + {{25{bias[7]}}, bias};
    if (biased < 33'sd0) begin
      pulse = 16'd0;
    end else if (biased > 33'sd65535) begin
      pulse = 16'hFFFF;
    end else begin
      pulse = biased[15:0];
    end
  end

endmodule

// ===== sv/scsp_parser.sv =====
// ----------------------------------------------------------------------------
// scsp_parser
// Frame state machine: move accumulators, fixed-position bias and stop
// frame recognition, and selection of the one result a word may cause.
// ----------------------------------------------------------------------------
module scsp_parser (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      step,
  input  logic [7:0]                ch,
  input  logic                      first_char,
  input  logic                      last_char,
  output scsp_pkg::res_t            res,
  output scsp_pkg::bias_wr_t        bias_wr,
  output logic [15:0]               move_servo,
  output logic signed [31:0]        move_pulse_acc
);

  typedef enum logic [1:0] {
    MODE_IDLE  = 2'd0,
    MODE_INDEX = 2'd1,
    MODE_PULSE = 2'd2,
    MODE_TIME  = 2'd3
  } mode_t;

  mode_t              mode_r, mode_nxt, cur_mode;
  logic [3:0]         pos_r, pos_nxt, cur_pos;
  logic [15:0]        idx_r, idx_nxt, cur_idx;
  logic signed [31:0] pacc_r, pacc_nxt, cur_pacc;
  logic [15:0]        tacc_r, tacc_nxt, cur_tacc;
  logic               pok_r, pok_nxt, cur_pok;
  logic [15:0]        fidx_r, fidx_nxt, cur_fidx;
  logic signed [10:0] fbias_r, fbias_nxt, cur_fbias;
  logic               fib_r, fib_nxt, cur_fib;
  logic [7:0]         sign_r, sign_nxt, cur_sign;
  logic               halted_r, halted_nxt, cur_halted;

  logic               stop_hit, bias_hit, move_hit, bias_ok, emit_move;
  logic signed [36:0] pw, pm;
  logic signed [15:0] bw, bm;
  logic signed [7:0]  bias_val;

  function automatic logic [15:0] acc16(input logic [15:0] acc, input logic [7:0] c);
    acc16 = (acc << 3) + (acc << 1) + {8'd0, c} - 16'd48;
  endfunction

  // a first mark restarts the string before the word is parsed
  assign cur_mode   = first_char ? MODE_IDLE : mode_r;
  assign cur_pos    = first_char ? 4'd0 : pos_r;
  assign cur_idx    = first_char ? 16'd0 : idx_r;
  assign cur_pacc   = first_char ? 32'sd0 : pacc_r;
  assign cur_tacc   = first_char ? 16'd0 : tacc_r;
  assign cur_pok    = first_char ? 1'b1 : pok_r;
  assign cur_fidx   = first_char ? 16'd0 : fidx_r;
  assign cur_fbias  = first_char ? 11'sd0 : fbias_r;
  assign cur_fib    = first_char ? 1'b0 : fib_r;
  assign cur_sign   = first_char ? 8'd0 : sign_r;
  assign cur_halted = first_char ? 1'b0 : halted_r;

  always_comb begin
    pw = {{5{cur_pacc[31]}}, cur_pacc};
    pm = (pw <<< 3) + (pw <<< 1) + $signed({29'd0, ch}) - 37'sd48;
    bw = {{5{cur_fbias[10]}}, cur_fbias};
    bm = (bw <<< 3) + (bw <<< 1) + $signed({8'd0, ch}) - 16'sd48;
    bias_val = (cur_sign == scsp_pkg::CH_PLUS) ? cur_fbias[7:0] : 8'sd0 - cur_fbias[7:0];
  end

  always_comb begin
    mode_nxt   = cur_mode;
    pos_nxt    = cur_pos;
    idx_nxt    = cur_idx;
    pacc_nxt   = cur_pacc;
    tacc_nxt   = cur_tacc;
    pok_nxt    = cur_pok;
    fidx_nxt   = cur_fidx;
    fbias_nxt  = cur_fbias;
    fib_nxt    = cur_fib;
    sign_nxt   = cur_sign;
    halted_nxt = cur_halted;
    stop_hit   = 1'b0;
    bias_hit   = 1'b0;
    move_hit   = 1'b0;
    bias_ok    = 1'b0;
    emit_move  = 1'b0;
    if (!cur_halted) begin
      if (ch == scsp_pkg::CH_NUL) begin
        emit_move  = (cur_mode == MODE_TIME);
        halted_nxt = 1'b1;
      end else begin
        if (cur_pok) begin
          case (cur_pos)
            4'd0: pok_nxt = (ch == scsp_pkg::CH_HASH);
            4'd1, 4'd2, 4'd3: fidx_nxt = acc16(cur_fidx, ch);
            4'd4: pok_nxt = (ch == scsp_pkg::CH_P);
            4'd5: begin
              if (ch == scsp_pkg::CH_S) fib_nxt = 1'b1;
              else if (ch == scsp_pkg::CH_D) fib_nxt = 1'b0;
              else pok_nxt = 1'b0;
            end
            4'd6: pok_nxt = (ch == (cur_fib ? scsp_pkg::CH_C : scsp_pkg::CH_S));
            4'd7: pok_nxt = (ch == (cur_fib ? scsp_pkg::CH_K : scsp_pkg::CH_T));
            4'd8: begin
              if (cur_fib) begin
                sign_nxt = ch;
              end else begin
                stop_hit = (ch == scsp_pkg::CH_BANG);
                pok_nxt  = 1'b0;
              end
            end
            4'd9, 4'd10, 4'd11: begin
              if (bm > 16'sd1023) fbias_nxt = 11'sd1023;
              else if (bm < -16'sd1024) fbias_nxt = -11'sd1024;
              else fbias_nxt = bm[10:0];
            end
            default: begin
              bias_hit = (ch == scsp_pkg::CH_BANG);
              pok_nxt  = 1'b0;
            end
          endcase
        end
        if (stop_hit) begin
          halted_nxt = 1'b1;
        end else begin
          case (cur_mode)
            MODE_INDEX: begin
              if (ch == scsp_pkg::CH_P) begin
                pacc_nxt = 32'sd0;
                mode_nxt = MODE_PULSE;
              end else begin
                idx_nxt = acc16(cur_idx, ch);
              end
            end
            MODE_PULSE: begin
              if (ch == scsp_pkg::CH_T) begin
                tacc_nxt = 16'd0;
                mode_nxt = MODE_TIME;
              end else if (pm > 37'sd2147483647) begin
                pacc_nxt = 32'sh7FFFFFFF;
              end else if (pm < -37'sd2147483648) begin
                pacc_nxt = 32'sh80000000;
              end else begin
                pacc_nxt = pm[31:0];
              end
            end
            MODE_TIME: begin
              if (ch == scsp_pkg::CH_BANG) begin
                move_hit = 1'b1;
                mode_nxt = MODE_IDLE;
              end else begin
                tacc_nxt = acc16(cur_tacc, ch);
              end
            end
            default: begin
              if (ch == scsp_pkg::CH_HASH) begin
                idx_nxt  = 16'd0;
                mode_nxt = MODE_INDEX;
              end else if (ch == scsp_pkg::CH_P) begin
                pacc_nxt = 32'sd0;
                mode_nxt = MODE_PULSE;
              end else if (ch == scsp_pkg::CH_T) begin
                tacc_nxt = 16'd0;
                mode_nxt = MODE_TIME;
              end
            end
          endcase
          bias_ok = bias_hit && cur_fbias >= scsp_pkg::BIAS_MIN &&
                    cur_fbias <= scsp_pkg::BIAS_MAX &&
                    cur_fidx < 16'(scsp_pkg::SERVO_COUNT) &&
                    (cur_sign == scsp_pkg::CH_PLUS || cur_sign == scsp_pkg::CH_MINUS);
          emit_move = !bias_ok && (move_hit || (last_char && mode_nxt == MODE_TIME));
          if (last_char) halted_nxt = 1'b1;
          if (cur_pos != 4'd15) pos_nxt = cur_pos + 4'd1;
        end
      end
    end
  end

  always_comb begin
    res.valid    = stop_hit || bias_ok || emit_move;
    res.kind     = scsp_pkg::KIND_MOVE;
    res.servo    = cur_idx;
    res.duration = tacc_nxt;
    res.offset   = 8'sd0;
    if (stop_hit) begin
      res.kind     = scsp_pkg::KIND_STOP;
      res.servo    = cur_fidx;
      res.duration = 16'd0;
    end else if (bias_ok) begin
      res.kind     = scsp_pkg::KIND_BIAS;
      res.servo    = cur_fidx;
      res.duration = 16'd0;
      res.offset   = bias_val;
    end
    bias_wr.en    = step && bias_ok;
    bias_wr.idx   = cur_fidx[scsp_pkg::BIAS_IW-1:0];
    bias_wr.value = bias_val;
  end

  assign move_servo     = cur_idx;
  assign move_pulse_acc = cur_pacc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_IDLE;
      pos_r    <= 4'd0;
      idx_r    <= 16'd0;
      pacc_r   <= 32'sd0;
      tacc_r   <= 16'd0;
      pok_r    <= 1'b1;
      fidx_r   <= 16'd0;
      fbias_r  <= 11'sd0;
      fib_r    <= 1'b0;
      sign_r   <= 8'd0;
      halted_r <= 1'b0;
    end else if (step) begin
      mode_r   <= mode_nxt;
      pos_r    <= pos_nxt;
      idx_r    <= idx_nxt;
      pacc_r   <= pacc_nxt;
      tacc_r   <= tacc_nxt;
      pok_r    <= pok_nxt;
      fidx_r   <= fidx_nxt;
      fbias_r  <= fbias_nxt;
      fib_r    <= fib_nxt;
      sign_r   <= sign_nxt;
      halted_r <= halted_nxt;
    end
  end

endmodule

// ===== sv/servo_command_string_parser.sv =====
// ----------------------------------------------------------------------------
// servo_command_string_parser
// Parses servo command strings one byte per word into move, bias set and
// stop results.
//
//   channel  ports                                         payload
//   in       in_valid / in_stall                           ch, first/last mark
//   out      out_valid / out_stall                         kind, servo, pulse,
//                                                          duration, offset
//
// One word per cycle sustained while out_stall is low; a result word passes
// through the input register, then the result register.
// Reset clears parser state, bias table and both valid flags.
// A stalled result holds in the result register; if the input register is
// empty, one more word is taken into it meanwhile, then in_stall rises.
// ----------------------------------------------------------------------------
module servo_command_string_parser (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_ch,
  input  logic               in_first_char,
  input  logic               in_last_char,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_kind,
  output logic [15:0]        out_servo,
  output logic [15:0]        out_pulse,
  output logic [15:0]        out_duration,
  output logic signed [7:0]  out_offset
);

  logic                 s1_valid_r;
  logic [7:0]           ch_r;
  logic                 first_r;
  logic                 last_r;
  logic                 can_load;
  logic                 step;
  logic                 in_accept;

  scsp_pkg::res_t       res;
  scsp_pkg::bias_wr_t   bias_wr;
  logic [15:0]          move_servo;
  logic signed [31:0]   move_pulse_acc;
  logic signed [7:0]    rd_bias;
  logic [15:0]          shaped_pulse;

  logic                 out_valid_r;
  scsp_pkg::kind_t      out_kind_r;
  logic [15:0]          out_servo_r;
  logic [15:0]          out_pulse_r;
  logic [15:0]          out_duration_r;
  logic signed [7:0]    out_offset_r;

  assign can_load  = !out_valid_r || !out_stall;
  assign step      = s1_valid_r && can_load;
  assign in_stall  = s1_valid_r && !can_load;
  assign in_accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_accept) begin
      s1_valid_r <= 1'b1;
    end else if (step) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      ch_r    <= in_ch;
      first_r <= in_first_char;
      last_r  <= in_last_char;
    end
  end

  scsp_parser u_parser (
    .clk            (clk),
    .rst_n          (rst_n),
    .step           (step),
    .ch             (ch_r),
    .first_char     (first_r),
    .last_char      (last_r),
    .res            (res),
    .bias_wr        (bias_wr),
    .move_servo     (move_servo),
    .move_pulse_acc (move_pulse_acc)
  );

  scsp_bias_table u_bias (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr       (bias_wr),
    .rd_servo (move_servo),
    .rd_bias  (rd_bias)
  );

  scsp_pulse_shape u_shape (
    .pulse_acc (move_pulse_acc),
    .servo     (move_servo),
    .bias      (rd_bias),
    .pulse     (shaped_pulse)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (can_load) begin
      out_valid_r <= step && res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step && res.valid && can_load) begin
      out_kind_r     <= res.kind;
      out_servo_r    <= res.servo;
      out_pulse_r    <= (res.kind == scsp_pkg::KIND_MOVE) ? shaped_pulse : 16'd0;
      out_duration_r <= res.duration;
      out_offset_r   <= res.offset;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_kind     = out_kind_r;
  assign out_servo    = out_servo_r;
  assign out_pulse    = out_pulse_r;
  assign out_duration = out_duration_r;
  assign out_offset   = out_offset_r;

endmodule

// ===== sv/scsp_checker.sv =====
// ----------------------------------------------------------------------------
// scsp_checker
// Port-level properties of the servo command string parser, bound to the
// top level.
// ----------------------------------------------------------------------------
`include "servo_command_string_parser_defines.svh"

module scsp_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input logic [1:0]        out_kind,
  input logic [15:0]       out_servo,
  input logic [15:0]       out_pulse,
  input logic [15:0]       out_duration,
  input logic signed [7:0] out_offset
);

  logic        stop_word;
  logic        bias_word;
  logic        move_word;
  logic [57:0] out_word;
  logic        stop_fields_ok;
  logic        bias_fields_ok;

  assign stop_word = out_valid && out_kind == scsp_pkg::KIND_STOP;
  assign bias_word = out_valid && out_kind == scsp_pkg::KIND_BIAS;
  assign move_word = out_valid && out_kind == scsp_pkg::KIND_MOVE;

  assign out_word = {out_kind, out_servo, out_pulse, out_duration, out_offset};

  assign stop_fields_ok = out_pulse == 16'd0 && out_duration == 16'd0 &&
                          out_offset == 8'sd0;
  assign bias_fields_ok = out_pulse == 16'd0 && out_duration == 16'd0 &&
                          out_offset >= -8'sd100 && out_offset <= 8'sd100 &&
                          out_servo < 16'(scsp_pkg::SERVO_COUNT);

  `SCSP_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_word))

  `SCSP_ASSERT_NOW(a_in_stall_cause, clk, rst_n, in_stall, out_valid && out_stall)

  `SCSP_ASSERT_NOW(a_stop_payload, clk, rst_n, stop_word, stop_fields_ok)

  `SCSP_ASSERT_NOW(a_bias_payload, clk, rst_n, bias_word, bias_fields_ok)

  `SCSP_ASSERT_NOW(a_move_offset, clk, rst_n, move_word, out_offset == 8'sd0)

endmodule

bind servo_command_string_parser scsp_checker u_scsp_checker (.*);
